// ===== design/lsdp_pkg.sv =====
// Shared widths, limits and the inter-cell link type of the LRU stack distance profiler.
package lsdp_pkg;

   localparam int ID_WIDTH            = 64;
   localparam int TIME_WIDTH          = 48;
   localparam int DIST_WIDTH          = 8;
   localparam int DIST_MAX            = 255;
   localparam int DEFAULT_STACK_DEPTH = 256;

   typedef struct packed {
      logic                  valid;
      logic [ID_WIDTH-1:0]   obj_id;
      logic                  hit;
      logic                  carry_valid;
      logic [ID_WIDTH-1:0]   carry_id;
      logic [TIME_WIDTH-1:0] carry_time;
      logic                  found;
      logic [DIST_WIDTH-1:0] distance;
      logic [TIME_WIDTH-1:0] prev_time;
   } link_type;

endpackage

// ===== design/lsdp_req_if.sv =====
// Request channel: one object identifier per transaction.
interface lsdp_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsdp_pkg::ID_WIDTH-1:0] object_id;

   modport source (output valid, output object_id, input ready);
   modport sink (input valid, input object_id, output ready);
endinterface

// ===== design/lsdp_rsp_if.sv =====
// Response channel: stack distance result per transaction.
interface lsdp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [lsdp_pkg::DIST_WIDTH-1:0] stack_distance;
   logic [lsdp_pkg::TIME_WIDTH-1:0] previous_time;
   logic [lsdp_pkg::TIME_WIDTH-1:0] current_time;

   modport source (output valid, output found, output stack_distance,
                   output previous_time, output current_time, input ready);
   modport sink (input valid, input found, input stack_distance,
                 input previous_time, input current_time, output ready);
endinterface

// ===== design/lsdp_cell.sv =====
// One LRU stack cell: holds one entry and swaps it with the travelling carry.
module lsdp_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lsdp_pkg::link_type up_link,
   output lsdp_pkg::link_type down_link
);

   logic [lsdp_pkg::ID_WIDTH-1:0]   entry_id_ff, entry_id_in;
   logic [lsdp_pkg::TIME_WIDTH-1:0] entry_time_ff, entry_time_in;
   logic                            entry_valid_ff, entry_valid_in;
   lsdp_pkg::link_type              link_ff, link_in;
   logic                            match;

   assign match = up_link.valid && !up_link.hit && entry_valid_ff &&
                  (entry_id_ff == up_link.obj_id);

   always_comb begin
      entry_id_in    = entry_id_ff;
      entry_time_in  = entry_time_ff;
      entry_valid_in = entry_valid_ff;
      link_in        = up_link;
      if (up_link.valid && !up_link.hit) begin
         entry_id_in         = up_link.carry_id;
         entry_time_in       = up_link.carry_time;
         entry_valid_in      = up_link.carry_valid;
         link_in.carry_id    = entry_id_ff;
         link_in.carry_time  = entry_time_ff;
         link_in.carry_valid = entry_valid_ff;
         if (match) begin
            link_in.hit         = 1'b1;
            link_in.carry_valid = 1'b0;
            if (CELL_INDEX <= lsdp_pkg::DIST_MAX) begin
               link_in.found     = 1'b1;
               link_in.distance  = lsdp_pkg::DIST_WIDTH'(CELL_INDEX);
               link_in.prev_time = entry_time_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         link_ff.valid  <= 1'b0;
      end else if (advance) begin
         entry_id_ff    <= entry_id_in;
         entry_time_ff  <= entry_time_in;
         entry_valid_ff <= entry_valid_in;
         link_ff        <= link_in;
      end
   end

   assign down_link = link_ff;

endmodule

// ===== design/lru_stack_distance_profiler.sv =====
// LRU stack distance profiler top level: request head, cell chain and response register.
// Each request walks down a systolic chain of STACK_DEPTH cells, one cell per cycle,
// pushing the object to the top and rippling displaced entries down until it meets its
// own earlier copy. A new request is taken every cycle while the response side keeps up;
// a request passes through the STACK_DEPTH cell registers and then the response register.
// A stalled response holds the whole chain. Objects found at depth 256 or more, first
// accesses and entries pushed off the bottom report found = 0. Timestamps are a 48-bit
// request count that wraps.
module lru_stack_distance_profiler #(
   parameter int STACK_DEPTH = lsdp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   lsdp_req_if.sink          req_port,
   lsdp_rsp_if.source        rsp_port
);

   lsdp_pkg::link_type              head_link;
   lsdp_pkg::link_type              chain [STACK_DEPTH];
   lsdp_pkg::link_type              tail_link;
   logic                            advance;
   logic [lsdp_pkg::TIME_WIDTH-1:0] req_time_ff, req_time_in;
   logic [lsdp_pkg::TIME_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff;
   logic [lsdp_pkg::DIST_WIDTH-1:0] rsp_dist_ff;
   logic [lsdp_pkg::TIME_WIDTH-1:0] rsp_prev_ff;
   logic [lsdp_pkg::TIME_WIDTH-1:0] rsp_time_ff;

   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   always_comb begin
      head_link             = '0;
      head_link.valid       = req_port.valid;
      head_link.obj_id      = req_port.object_id;
      head_link.carry_valid = 1'b1;
      head_link.carry_id    = req_port.object_id;
      head_link.carry_time  = req_time_ff;
   end

   genvar g;
   generate
      for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_first
            lsdp_cell #(.CELL_INDEX(g)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .advance   (advance),
               .up_link   (head_link),
               .down_link (chain[g])
            );
         end else begin : g_rest
            lsdp_cell #(.CELL_INDEX(g)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .advance   (advance),
               .up_link   (chain[g-1]),
               .down_link (chain[g])
            );
         end
      end
   endgenerate

   assign tail_link = chain[STACK_DEPTH-1];

   always_comb begin
      req_time_in  = req_time_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_port.valid && advance) begin
         req_time_in = req_time_ff + 1'b1;
      end
      if (advance) begin
         rsp_valid_in = tail_link.valid;
         if (tail_link.valid) begin
            rsp_count_in = rsp_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_time_ff  <= '0;
         rsp_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_time_ff  <= req_time_in;
         rsp_count_ff <= rsp_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_found_ff <= tail_link.found;
         rsp_dist_ff  <= tail_link.distance;
         rsp_prev_ff  <= tail_link.prev_time;
         rsp_time_ff  <= rsp_count_ff;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.found          = rsp_found_ff;
   assign rsp_port.stack_distance = rsp_dist_ff;
   assign rsp_port.previous_time  = rsp_prev_ff;
   assign rsp_port.current_time   = rsp_time_ff;

`ifndef NO_ASSERTIONS
   a_head_enters: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=>
         (chain[0].valid && chain[0].obj_id == $past(req_port.object_id)))
      else $error("accepted request did not enter the first cell");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.found) |->
         (rsp_port.stack_distance == '0 && rsp_port.previous_time == '0))
      else $error("not-found response carries a distance or time");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tail_link))
      else $error("chain moved while the response was stalled");

   a_time_order: assert property (@(posedge clock) disable iff (reset)
      (advance && tail_link.valid) |=>
         (rsp_port.valid && rsp_port.current_time == $past(rsp_count_ff)))
      else $error("response timestamp out of sequence");

   a_hit_drops_carry: assert property (@(posedge clock) disable iff (reset)
      (tail_link.valid && tail_link.hit) |-> !tail_link.carry_valid)
      else $error("hit request still carries an entry");
`endif

endmodule

// ===== tb/lsdp_distance_checker.sv =====
// Checker for the LRU stack distance profiler: tracks the LRU stack and compares every response.
`timescale 1ns / 1ps

module lsdp_distance_checker #(
   parameter int STACK_DEPTH = lsdp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic clock,
   input  logic reset,
   lsdp_req_if  req_mon,
   lsdp_rsp_if  rsp_mon,
   output int   errors,
   output int   outstanding
);

   typedef struct packed {
      logic                            found;
      logic [lsdp_pkg::DIST_WIDTH-1:0] distance;
      logic [lsdp_pkg::TIME_WIDTH-1:0] prev_time;
      logic [lsdp_pkg::TIME_WIDTH-1:0] cur_time;
   } distance_result_type;

   logic [lsdp_pkg::ID_WIDTH-1:0]   lru_ids [STACK_DEPTH];
   logic [lsdp_pkg::TIME_WIDTH-1:0] lru_times [STACK_DEPTH];
   logic [STACK_DEPTH-1:0]          lru_held;
   logic [lsdp_pkg::TIME_WIDTH-1:0] access_count;
   distance_result_type             expected_results[$];
   int                              mismatches = 0;

   assign errors = mismatches;

   task automatic access_object(input logic [lsdp_pkg::ID_WIDTH-1:0] id,
                                output distance_result_type res);
      int pos;
      bit present;
      pos     = STACK_DEPTH - 1;
      present = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (!present && lru_held[i] && lru_ids[i] == id) begin
            pos     = i;
            present = 1'b1;
         end
      end
      if (present && pos <= lsdp_pkg::DIST_MAX) begin
         res.found     = 1'b1;
         res.distance  = pos[lsdp_pkg::DIST_WIDTH-1:0];
         res.prev_time = lru_times[pos];
      end else begin
         res.found     = 1'b0;
         res.distance  = '0;
         res.prev_time = '0;
      end
      res.cur_time = access_count;
      // shift everything above the hit down by one; on a miss the bottom entry drops
      for (int i = pos; i > 0; i--) begin
         lru_ids[i]   = lru_ids[i-1];
         lru_times[i] = lru_times[i-1];
         lru_held[i]  = lru_held[i-1];
      end
      lru_ids[0]   = id;
      lru_times[0] = access_count;
      lru_held[0]  = 1'b1;
      access_count = access_count + 1'b1;
   endtask

   always @(posedge clock) begin
      distance_result_type want;
      distance_result_type got;
      if (reset) begin
         lru_held     = '0;
         access_count = '0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.found, rsp_mon.stack_distance, rsp_mon.previous_time,
                    rsp_mon.current_time};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transaction found=%0b dist=%0d prev=%0d cur=%0d",
                           $realtime, got.found, got.distance, got.prev_time, got.cur_time);
            end else begin
               want = expected_results.pop_front();
               if (got.found !== want.found || got.distance !== want.distance ||
                   got.prev_time !== want.prev_time || got.cur_time !== want.cur_time) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch exp found=%0b dist=%0d prev=%0d cur=%0d",
                               " got found=%0b dist=%0d prev=%0d cur=%0d"}, $realtime,
                              want.found, want.distance, want.prev_time, want.cur_time,
                              got.found, got.distance, got.prev_time, got.cur_time);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            access_object(req_mon.object_id, want);
            expected_results.push_back(want);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== tb/tb_lru_stack_distance_profiler.sv =====
// Testbench top for the LRU stack distance profiler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lru_stack_distance_profiler;
   import lsdp_pkg::*;

   localparam int DEPTH        = 264;
   localparam int HOLD_CYCLES  = 700;
   localparam int LIMIT_CYCLES = 250000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   int   hold_requests;
   int   errors;
   int   outstanding;
   int   cycle_count = 0;
   logic [ID_WIDTH-1:0] sent_ids[$];

   lsdp_req_if req_ch();
   lsdp_rsp_if rsp_ch();

   lru_stack_distance_profiler #(.STACK_DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   lsdp_distance_checker #(.STACK_DEPTH(DEPTH)) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** lru_stack_distance_profiler: FAILED **");
         $finish;
      end
   end

   initial begin
      int seen;
      int hold_left;
      seen          = 0;
      hold_left     = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen) begin
            seen      = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [ID_WIDTH-1:0] fresh_id();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [ID_WIDTH-1:0] pick_object();
      int r;
      int n;
      r = $urandom_range(99);
      n = sent_ids.size();
      if (n == 0 || r < 25)
         return fresh_id();
      if (r < 65)
         return sent_ids[$urandom_range((n > 16) ? 15 : n - 1)];
      if (r < 85)
         return sent_ids[$urandom_range((n > 300) ? 299 : n - 1)];
      if (n > 300)
         return sent_ids[$urandom_range(n - 1, 240)];
      return fresh_id();
   endfunction

   task automatic send_object(input logic [ID_WIDTH-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.object_id <= id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent_ids.push_front(id);
      if (sent_ids.size() > 512) void'(sent_ids.pop_back());
   endtask

   // walk a loop of distinct objects twice: every second-pass access sits at depth n-1
   task automatic run_loop(input int n);
      logic [ID_WIDTH-1:0] loop_ids[$];
      for (int i = 0; i < n; i++) loop_ids.push_back(fresh_id());
      for (int pass = 0; pass < 2; pass++)
         foreach (loop_ids[i]) send_object(loop_ids[i]);
   endtask

   task automatic run_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (count) send_object(pick_object());
   endtask

   initial begin
      logic [ID_WIDTH-1:0] directed_ids[$];
      clock            = 1'b0;
      reset            = 1'b1;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_requests    = 0;
      req_ch.valid     = 1'b0;
      req_ch.object_id = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_ids = '{64'h0, {ID_WIDTH{1'b1}}, 64'h0, 64'h0, {ID_WIDTH{1'b1}},
                       64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h1,
                       64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                       64'hAAAA_AAAA_AAAA_AAAA, {ID_WIDTH{1'b1}}, 64'h0};
      foreach (directed_ids[i]) send_object(directed_ids[i]);

      send_idle_pct = 46;
      run_loop(256);
      send_idle_pct = 0;
      stall_pct     = 46;
      run_loop(260);

      // hold the response side off while requests keep coming
      stall_pct = 0;
      hold_requests++;
      run_random(350, 0, 0);
      run_random(100, 46, 0);
      run_random(100, 0, 46);
      run_random(100, 14, 14);
      req_ch.valid <= 1'b0;

      wait (outstanding == 0);
      repeat (DEPTH + 16) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("** lru_stack_distance_profiler: PASSED **");
      else
         $display("** lru_stack_distance_profiler: FAILED **");
      $finish;
   end

endmodule
